// ===== sv/lifegs_pkg.sv =====
// ----------------------------------------------------------------------------
// Life grid step package
// Shared sizes, request codes and controller states for the B3/S23 grid core.
// ----------------------------------------------------------------------------
package lifegs_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int ROW_AW    = $clog2(MAX_ROWS);
    localparam int COL_AW    = $clog2(MAX_COLS);
    localparam int SIZE_W    = 7;
    localparam int COUNT_W   = 13;
    localparam int POP_W     = $clog2(MAX_COLS + 1);
    localparam int CFG_AW    = 1;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = 13'd8191;
    localparam int                 LIVE_LIMIT = MAX_ROWS * MAX_COLS;

    localparam logic [CFG_AW-1:0] REG_GRID_ROWS = 1'b0;
    localparam logic [CFG_AW-1:0] REG_GRID_COLS = 1'b1;

    typedef enum logic [1:0] {
        REQ_WRITE   = 2'd0,
        REQ_READ    = 2'd1,
        REQ_ADVANCE = 2'd2,
        REQ_NOP     = 2'd3
    } req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL,
        ST_ADV_FILL,
        ST_ADV_RUN,
        ST_ADV_COUNT,
        ST_DONE
    } state_t;

endpackage

// ===== sv/lifegs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module lifegs_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/life_automaton_grid_step_core.sv =====
// ----------------------------------------------------------------------------
// Life automaton grid step core
// Bounded B3/S23 grid held one row per memory word, with cell access and a
// row-serial generation step.
// ----------------------------------------------------------------------------
// The input stream carries one request per transaction: s_tuser selects write
// cell, read cell, advance one generation or no operation; s_tdata holds the
// cell address and the value to write. Every request returns exactly one
// transaction on the output stream with the addressed cell (reads only) and
// the live count of the latest generation.
// Grid size is set through cfg_wr_en/cfg_addr/cfg_wr_data; the user writes it only
// while the core idles, which the core itself does not enforce. A no-operation goes
// from acceptance straight to the result state; a cell read or write first reads
// the row word, and a write then modifies it and writes it back. An advance reads
// row 0, then reads, updates and writes back one row word per cycle through the
// grid memory, followed by a state that finishes the live count.
// One request is in flight at a time; a new one is accepted once the previous
// result sits in the output register, even if the receiver has not taken it.
// If the receiver stalls, a finished result waits until the register frees up.
// Reset clears every row valid flag, so the grid reads as all dead at once,
// sets both sizes to 64 and the live count to zero; no clearing sweep is needed.
// ----------------------------------------------------------------------------
module life_automaton_grid_step_core (
    input  logic        aclk,
    input  logic        aresetn,
    // Configuration write port
    input  logic        cfg_wr_en,
    input  logic [0:0]  cfg_addr,
    input  logic [6:0]  cfg_wr_data,
    // Request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,     // [5:0] row_index, [11:6] col_index, [12] alive_in
    input  logic [1:0]  s_tuser,     // [1:0] req_type
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata      // [0] cell_alive, [13:1] live_count
);

    localparam int RW = lifegs_pkg::ROW_AW;
    localparam int CW = lifegs_pkg::COL_AW;
    localparam int SW = lifegs_pkg::SIZE_W;
    localparam int NW = lifegs_pkg::COUNT_W;
    localparam int MC = lifegs_pkg::MAX_COLS;

    function automatic logic [SW-1:0] clamp_size(input logic [SW-1:0] v,
                                                 input logic [SW-1:0] maxv);
        logic [SW-1:0] r;
        r = v;
        if (v == '0) begin
            r = SW'(1);
        end else if (v > maxv) begin
            r = maxv;
        end
        return r;
    endfunction

    // Registers
    lifegs_pkg::state_t state_reg, state_next;
    lifegs_pkg::req_t   req_reg, req_next;
    logic [RW-1:0]  row_reg, row_next;
    logic [CW-1:0]  col_reg, col_next;
    logic           alive_reg, alive_next;
    logic [SW-1:0]  grid_rows_reg, grid_rows_next;
    logic [SW-1:0]  grid_cols_reg, grid_cols_next;
    logic [NW-1:0]  live_total_reg, live_total_next;
    logic [NW-1:0]  acc_reg, acc_next;
    logic [RW-1:0]  adv_row_reg, adv_row_next;
    logic [MC-1:0]  prev_reg, prev_next;
    logic [MC-1:0]  cur_reg, cur_next;
    logic [MC-1:0]  pop_row_reg, pop_row_next;
    logic           cnt_en_reg, cnt_en_next;
    logic           res_cell_reg, res_cell_next;
    logic           rd_valid_reg;
    logic [lifegs_pkg::MAX_ROWS-1:0] row_valid_reg, row_valid_next;
    logic           m_tvalid_reg, m_tvalid_next;
    logic           m_cell_reg, m_cell_next;
    logic [NW-1:0]  m_count_reg, m_count_next;

    // Combinational signals
    logic           accept;
    lifegs_pkg::req_t in_req;
    logic [SW-1:0]  nr_eff, nc_eff;
    logic [MC-1:0]  col_mask;
    logic           ram_rd_en, ram_wr_en;
    logic [RW-1:0]  ram_rd_addr, ram_wr_addr;
    logic [MC-1:0]  ram_wr_data, ram_rd_data, rd_row;
    logic           in_grid;
    logic           last_row;
    logic [MC-1:0]  new_row;
    logic [lifegs_pkg::POP_W-1:0] pop;
    logic [NW:0]    acc_sum;
    logic [NW-1:0]  acc_sat;

    assign accept   = s_tvalid && s_tready;
    assign in_req   = lifegs_pkg::req_t'(s_tuser);
    assign s_tready = (state_reg == lifegs_pkg::ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {2'b00, m_count_reg, m_cell_reg};

    assign nr_eff = clamp_size(grid_rows_reg, SW'(lifegs_pkg::MAX_ROWS));
    assign nc_eff = clamp_size(grid_cols_reg, SW'(lifegs_pkg::MAX_COLS));

    always_comb begin
        for (int c = 0; c < MC; c++) begin
            col_mask[c] = (SW'(c) < nc_eff);
        end
    end

    // A row that was never written since reset reads as all dead.
    assign rd_row   = rd_valid_reg ? ram_rd_data : '0;
    assign in_grid  = ({1'b0, row_reg} < nr_eff) && ({1'b0, col_reg} < nc_eff);
    assign last_row = ((SW'(adv_row_reg) + SW'(1)) == nr_eff);

    // Next generation of the current row from the three-row window. Columns
    // outside the active width neither count nor change.
    always_comb begin
        logic [MC-1:0] p, m, n;
        logic [3:0]    nsum;
        p = prev_reg & col_mask;
        m = cur_reg & col_mask;
        n = last_row ? '0 : (rd_row & col_mask);
        for (int c = 0; c < MC; c++) begin
            nsum = 4'(p[c]) + 4'(n[c]);
            if (c > 0) begin
                nsum = nsum + 4'(p[c-1]) + 4'(m[c-1]) + 4'(n[c-1]);
            end
            if (c < MC - 1) begin
                nsum = nsum + 4'(p[c+1]) + 4'(m[c+1]) + 4'(n[c+1]);
            end
            if (col_mask[c]) begin
                new_row[c] = (nsum == 4'd3) || ((nsum == 4'd2) && m[c]);
            end else begin
                new_row[c] = cur_reg[c];
            end
        end
    end

    assign pop     = lifegs_pkg::POP_W'($countones(pop_row_reg));
    assign acc_sum = {1'b0, acc_reg} + (NW + 1)'(pop);
    assign acc_sat = (acc_sum > (NW + 1)'(lifegs_pkg::COUNT_MAX)) ?
                     lifegs_pkg::COUNT_MAX : acc_sum[NW-1:0];

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        alive_next      = alive_reg;
        grid_rows_next  = grid_rows_reg;
        grid_cols_next  = grid_cols_reg;
        live_total_next = live_total_reg;
        acc_next        = acc_reg;
        adv_row_next    = adv_row_reg;
        prev_next       = prev_reg;
        cur_next        = cur_reg;
        pop_row_next    = pop_row_reg;
        cnt_en_next     = 1'b0;
        res_cell_next   = res_cell_reg;
        row_valid_next  = row_valid_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        m_cell_next     = m_cell_reg;
        m_count_next    = m_count_reg;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = '0;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = adv_row_reg;
        ram_wr_data     = new_row;

        if (cfg_wr_en) begin
            case (cfg_addr)
                lifegs_pkg::REG_GRID_ROWS: grid_rows_next = cfg_wr_data;
                lifegs_pkg::REG_GRID_COLS: grid_cols_next = cfg_wr_data;
                default: ;
            endcase
        end

        case (state_reg)
            lifegs_pkg::ST_IDLE: begin
                if (accept) begin
                    req_next     = in_req;
                    row_next     = s_tdata[RW-1:0];
                    col_next     = s_tdata[6 +: CW];
                    alive_next   = s_tdata[12];
                    acc_next     = '0;
                    adv_row_next = '0;
                    case (in_req)
                        lifegs_pkg::REQ_WRITE, lifegs_pkg::REQ_READ: begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = s_tdata[RW-1:0];
                            state_next  = lifegs_pkg::ST_CELL;
                        end
                        lifegs_pkg::REQ_ADVANCE: begin
                            ram_rd_en   = 1'b1;
                            ram_rd_addr = '0;
                            state_next  = lifegs_pkg::ST_ADV_FILL;
                        end
                        default: begin
                            res_cell_next = 1'b0;
                            state_next    = lifegs_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            lifegs_pkg::ST_CELL: begin
                res_cell_next = 1'b0;
                if (req_reg == lifegs_pkg::REQ_READ) begin
                    res_cell_next = in_grid && rd_row[col_reg];
                end else if (in_grid) begin
                    ram_wr_en              = 1'b1;
                    ram_wr_addr            = row_reg;
                    ram_wr_data            = rd_row;
                    ram_wr_data[col_reg]   = alive_reg;
                    row_valid_next[row_reg] = 1'b1;
                end
                state_next = lifegs_pkg::ST_DONE;
            end
            lifegs_pkg::ST_ADV_FILL: begin
                prev_next   = '0;
                cur_next    = rd_row;
                ram_rd_en   = (nr_eff > SW'(1));
                ram_rd_addr = RW'(1);
                state_next  = lifegs_pkg::ST_ADV_RUN;
            end
            lifegs_pkg::ST_ADV_RUN: begin
                // Row r is written back after row r+1 has been read, so the
                // window always holds the previous generation.
                ram_wr_en                   = 1'b1;
                ram_wr_addr                 = adv_row_reg;
                ram_wr_data                 = new_row;
                row_valid_next[adv_row_reg] = 1'b1;
                pop_row_next = new_row & col_mask;
                cnt_en_next  = 1'b1;
                if (cnt_en_reg) begin
                    acc_next = acc_sat;
                end
                prev_next   = cur_reg;
                cur_next    = rd_row;
                ram_rd_en   = ((SW'(adv_row_reg) + SW'(2)) < nr_eff);
                ram_rd_addr = adv_row_reg + RW'(2);
                if (last_row) begin
                    state_next = lifegs_pkg::ST_ADV_COUNT;
                end else begin
                    adv_row_next = adv_row_reg + RW'(1);
                end
            end
            lifegs_pkg::ST_ADV_COUNT: begin
                live_total_next = acc_sat;
                res_cell_next   = 1'b0;
                state_next      = lifegs_pkg::ST_DONE;
            end
            lifegs_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_cell_next   = res_cell_reg;
                    m_count_next  = live_total_reg;
                    state_next    = lifegs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lifegs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= lifegs_pkg::ST_IDLE;
            grid_rows_reg  <= SW'(lifegs_pkg::MAX_ROWS);
            grid_cols_reg  <= SW'(lifegs_pkg::MAX_COLS);
            live_total_reg <= '0;
            cnt_en_reg     <= 1'b0;
            row_valid_reg  <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            grid_rows_reg  <= grid_rows_next;
            grid_cols_reg  <= grid_cols_next;
            live_total_reg <= live_total_next;
            cnt_en_reg     <= cnt_en_next;
            row_valid_reg  <= row_valid_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg      <= req_next;
        row_reg      <= row_next;
        col_reg      <= col_next;
        alive_reg    <= alive_next;
        acc_reg      <= acc_next;
        adv_row_reg  <= adv_row_next;
        prev_reg     <= prev_next;
        cur_reg      <= cur_next;
        pop_row_reg  <= pop_row_next;
        res_cell_reg <= res_cell_next;
        m_cell_reg   <= m_cell_next;
        m_count_reg  <= m_count_next;
        if (ram_rd_en) begin
            rd_valid_reg <= row_valid_reg[ram_rd_addr];
        end
    end

    lifegs_ram #(
        .WIDTH (MC),
        .DEPTH (lifegs_pkg::MAX_ROWS)
    ) u_grid_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // The grid memory is only written while a cell update or a sweep runs.
    a_wr_only_when_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_wr_en |-> (state_reg == lifegs_pkg::ST_CELL ||
                       state_reg == lifegs_pkg::ST_ADV_RUN))
        else $error("grid memory written outside an update");

    // A sweep never writes a row beyond the active height.
    a_sweep_in_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        (ram_wr_en && state_reg == lifegs_pkg::ST_ADV_RUN) |->
            ({1'b0, ram_wr_addr} < nr_eff))
        else $error("sweep wrote a row outside the active grid");

    // The live count only moves at the end of a generation.
    a_live_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != lifegs_pkg::ST_ADV_COUNT) |=> $stable(live_total_reg))
        else $error("live count changed outside a generation end");

    // The count can never exceed the number of cells in the grid.
    a_live_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        live_total_reg <= NW'(lifegs_pkg::LIVE_LIMIT))
        else $error("live count above grid size");

    // An accepted request always leaves the idle state.
    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> (state_reg != lifegs_pkg::ST_IDLE))
        else $error("request accepted without starting work");

endmodule
